[hdl/double_ended_queue_macros.svh]
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Clocked check, off while reset is asserted
`define DEQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked check that also holds during reset
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/deq_pkg.sv]
`default_nettype none

package deq_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SW    = CW + 1;
	localparam int DW    = 32;

	typedef enum logic [2:0] {
		OP_PUSH_HEAD = 3'd0,
		OP_PUSH_TAIL = 3'd1,
		OP_POP_HEAD  = 3'd2,
		OP_POP_TAIL  = 3'd3,
		OP_DUMP      = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		KIND_PUSHED     = 3'd0,
		KIND_POPPED     = 3'd1,
		KIND_POP_EMPTY  = 3'd2,
		KIND_PUSH_FULL  = 3'd3,
		KIND_LISTED     = 3'd4,
		KIND_LIST_EMPTY = 3'd5
	} kind_t;

	typedef struct packed {
		logic [2:0]           opcode;
		logic signed [DW-1:0] value;
	} cmd_t;

	typedef struct packed {
		kind_t                kind;
		logic signed [DW-1:0] data;
		logic                 last;
	} rsp_t;

	// base + off, folded back into the ring (sum stays below 2*DEPTH)
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

endpackage

`default_nettype wire

[hdl/deq_ram.sv]
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port; rdata holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/double_ended_queue.sv]
// Response path: rsp_valid rises once an accepted command has passed stage 1 (with the RAM
// read) and then the output register; a dump's first entry comes later, as its reads start
// only after the dump command is taken.
// Throughput: one push or pop per cycle while cmd_stall is low, set by the single RAM port used per command.
// A dump streams one entry per unstalled cycle; cmd_stall stays up until its last read issues.
// Reset: head and count clear to zero, pipeline valids clear; RAM contents are not cleared.
`default_nettype none

module double_ended_queue import deq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	typedef enum logic {S_IDLE, S_DUMP} state_t;

	state_t               state_q;
	logic [AW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [CW-1:0]        left_q;

	logic                 valid_s1;
	kind_t                kind_s1;
	logic                 last_s1;
	logic                 ram_s1;

	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 out_free;
	logic                 adv_s1;
	logic                 slot_free;
	logic                 accept;
	logic                 is_full;
	logic                 is_empty;
	logic                 push_ok;
	logic                 pop_ok;
	logic                 dump_issue;
	logic [AW-1:0]        head_dec;
	logic [AW-1:0]        tail_wr;
	logic [AW-1:0]        tail_rd;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [DW-1:0]        ram_rdata;

	// handshake and stage movement
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign adv_s1     = valid_s1 && out_free;
	assign slot_free  = !valid_s1 || out_free;
	assign cmd_stall  = !((state_q == S_IDLE) && slot_free);
	assign accept     = cmd_valid && !cmd_stall;
	assign dump_issue = (state_q == S_DUMP) && slot_free;

	// ring addressing
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign tail_wr  = ring_add(head_q, count_q);
	assign tail_rd  = ring_add(head_q, count_q - 1'b1);

	assign push_ok = accept && !is_full &&
		(cmd.opcode == OP_PUSH_HEAD || cmd.opcode == OP_PUSH_TAIL);
	assign pop_ok  = accept && !is_empty &&
		(cmd.opcode == OP_POP_HEAD || cmd.opcode == OP_POP_TAIL);

	// one access per cycle; a write always lands in the RAM before any read of that entry
	assign ram_we    = push_ok;
	assign ram_waddr = (cmd.opcode == OP_PUSH_HEAD) ? head_dec : tail_wr;
	assign ram_re    = pop_ok || dump_issue;
	assign ram_raddr = dump_issue ? rd_ptr_q :
		((cmd.opcode == OP_POP_HEAD) ? head_q : tail_rd);

	deq_ram #(
		.WIDTH (DW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control, stage 1 and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			left_q      <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				rsp_valid_q <= valid_s1;
			end
			if (adv_s1) begin
				rsp_q.kind <= kind_s1;
				rsp_q.data <= ram_s1 ? ram_rdata : '0;
				rsp_q.last <= last_s1;
				valid_s1   <= 1'b0;
			end

			if (accept) begin
				case (cmd.opcode)
					OP_PUSH_HEAD, OP_PUSH_TAIL: begin
						valid_s1 <= 1'b1;
						last_s1  <= 1'b1;
						ram_s1   <= 1'b0;
						if (is_full) begin
							kind_s1 <= KIND_PUSH_FULL;
						end else begin
							kind_s1 <= KIND_PUSHED;
							count_q <= count_q + 1'b1;
							if (cmd.opcode == OP_PUSH_HEAD) begin
								head_q <= head_dec;
							end
						end
					end
					OP_POP_HEAD, OP_POP_TAIL: begin
						valid_s1 <= 1'b1;
						last_s1  <= 1'b1;
						if (is_empty) begin
							kind_s1 <= KIND_POP_EMPTY;
							ram_s1  <= 1'b0;
						end else begin
							kind_s1 <= KIND_POPPED;
							ram_s1  <= 1'b1;
							count_q <= count_q - 1'b1;
							if (cmd.opcode == OP_POP_HEAD) begin
								head_q <= ring_add(head_q, CW'(1));
							end
						end
					end
					OP_DUMP: begin
						if (is_empty) begin
							valid_s1 <= 1'b1;
							last_s1  <= 1'b1;
							ram_s1   <= 1'b0;
							kind_s1  <= KIND_LIST_EMPTY;
						end else begin
							state_q  <= S_DUMP;
							rd_ptr_q <= head_q;
							left_q   <= count_q;
						end
					end
					default: begin
						// unused opcode: consumed with no response
					end
				endcase
			end

			// dump walk: one read per free slot, head to tail
			if (dump_issue) begin
				valid_s1 <= 1'b1;
				kind_s1  <= KIND_LISTED;
				ram_s1   <= 1'b1;
				last_s1  <= (left_q == CW'(1));
				rd_ptr_q <= ring_add(rd_ptr_q, CW'(1));
				left_q   <= left_q - 1'b1;
				if (left_q == CW'(1)) begin
					state_q <= S_IDLE;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[hdl/deq_checker.sv]
`default_nettype none

`include "double_ended_queue_macros.svh"

module deq_assertions import deq_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	logic rsp_held;
	logic has_data;
	logic mid_rsp;

	assign rsp_held = rsp_valid && rsp_stall;
	assign has_data = (rsp.kind == KIND_POPPED) || (rsp.kind == KIND_LISTED);
	assign mid_rsp  = rsp_valid && !rsp.last;

	// a stalled response transaction stays put
	`DEQ_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid && $stable(rsp), "stalled rsp changed")

	// nothing leaves while reset is held
	`DEQ_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !rsp_valid, "rsp_valid during reset")

	// only pops and listed entries carry data
	`DEQ_ASSERT(a_data_zero, rsp_valid && !has_data |-> rsp.data == '0, "data on status rsp")

	// only a dump produces more than one response per command
	`DEQ_ASSERT(a_multi_listed, mid_rsp |-> rsp.kind == KIND_LISTED, "non-final rsp not listed")

endmodule

bind double_ended_queue deq_assertions u_deq_assertions (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
